// ===== rtl/mrf_pkg.sv =====
`timescale 1ns / 1ps

package mrf_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 36;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] SUM_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] SUM_LAST  = IDX_W'(33);
  localparam logic [IDX_W-1:0] CRC_FIRST = IDX_W'(26);
  localparam logic [IDX_W-1:0] CRC_LAST  = IDX_W'(31);

  // Fixed frame bytes
  localparam logic [7:0] START_BYTE = 8'hA5;
  localparam logic [7:0] LEN_LO     = 8'd23;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] CTRL_LO    = 8'h10;
  localparam logic [7:0] CTRL_HI    = 8'h45;
  localparam logic [7:0] HDR_TYPE   = 8'h02;
  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] END_BYTE   = 8'h15;

  // CRC-16 constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOGGER_SERIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_ID       = 1'b1;
  localparam logic [7:0]           UNIT_ID_RESET     = 8'h01;

  // Default queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // One queued request with everything needed to build its frame
  typedef struct packed {
    logic [31:0] serial;
    logic [15:0] seq;
    logic [7:0]  unit;
    logic [15:0] start_reg;
    logic [15:0] num_regs;
  } mrf_req_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } mrf_qstat_t;

  // One byte of the reflected CRC-16 update
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrf_front.sv =====
`timescale 1ns / 1ps

module mrf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,
  input  logic                            cfg_wr_en,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  mrf_pkg::mrf_qstat_t             q_stat,
  output logic                            push,
  output mrf_pkg::mrf_req_t               push_req
);
  import mrf_pkg::*;

  logic [31:0] serial_r;
  logic [7:0]  unit_r;
  logic [15:0] seq_r;

  // A request is taken whenever the queue has room
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // Snapshot of the request and of the settings that go into its frame
  always_comb begin
    push_req.serial    = serial_r;
    push_req.seq       = seq_r;
    push_req.unit      = unit_r;
    push_req.start_reg = in_tdata[15:0];
    push_req.num_regs  = in_tdata[31:16];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_r <= '0;
      unit_r   <= UNIT_ID_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LOGGER_SERIAL: serial_r <= cfg_wdata;
        REG_UNIT_ID:       unit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sequence number advances once per accepted request and wraps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (push) begin
      seq_r <= seq_r + 16'd1;
    end
  end

endmodule

// ===== rtl/mrf_queue.sv =====
`timescale 1ns / 1ps

module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  mrf_pkg::mrf_req_t          push_req,
  input  logic                       pop,
  output mrf_pkg::mrf_req_t          head_req,
  output mrf_pkg::mrf_qstat_t        q_stat,
  output logic [$clog2(DEPTH+1)-1:0] q_count
);
  import mrf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mrf_req_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head_req     = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign q_count      = count_r;

  // Storage slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mrf_back.sv =====
`timescale 1ns / 1ps

module mrf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mrf_pkg::mrf_req_t   head_req,
  input  mrf_pkg::mrf_qstat_t q_stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);
  import mrf_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic [15:0]      crc_r;
  logic [7:0]       sum_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             advance;
  logic             load;
  logic [7:0]       cur_byte;

  // The output register moves when empty or when its byte is taken
  assign advance = !out_valid_r || out_tready;
  assign load    = advance && !q_stat.empty;
  assign pop     = load && (idx_r == LAST_IDX);

  // Byte selection for the current frame position
  always_comb begin
    unique case (idx_r) inside
      6'd0:        cur_byte = START_BYTE;
      6'd1:        cur_byte = LEN_LO;
      6'd2:        cur_byte = LEN_HI;
      6'd3:        cur_byte = CTRL_LO;
      6'd4:        cur_byte = CTRL_HI;
      6'd5:        cur_byte = head_req.seq[7:0];
      6'd6:        cur_byte = head_req.seq[15:8];
      6'd7:        cur_byte = head_req.serial[7:0];
      6'd8:        cur_byte = head_req.serial[15:8];
      6'd9:        cur_byte = head_req.serial[23:16];
      6'd10:       cur_byte = head_req.serial[31:24];
      6'd11:       cur_byte = HDR_TYPE;
      [6'd12:6'd25]: cur_byte = 8'h00;
      6'd26:       cur_byte = head_req.unit;
      6'd27:       cur_byte = FUNC_READ;
      6'd28:       cur_byte = head_req.start_reg[15:8];
      6'd29:       cur_byte = head_req.start_reg[7:0];
      6'd30:       cur_byte = head_req.num_regs[15:8];
      6'd31:       cur_byte = head_req.num_regs[7:0];
      6'd32:       cur_byte = crc_r[7:0];
      6'd33:       cur_byte = crc_r[15:8];
      6'd34:       cur_byte = sum_r;
      6'd35:       cur_byte = END_BYTE;
      default:     cur_byte = 8'h00;
    endcase
  end

  // Byte counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= !q_stat.empty;
      if (load) begin
        idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  // Output payload, running CRC and running checksum
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= cur_byte;
      out_last_r <= (idx_r == LAST_IDX);
      if (idx_r == '0) begin
        crc_r <= CRC_INIT;
        sum_r <= '0;
      end else begin
        if (idx_r >= CRC_FIRST && idx_r <= CRC_LAST) begin
          crc_r <= crc16_byte(crc_r, cur_byte);
        end
        if (idx_r >= SUM_FIRST && idx_r <= SUM_LAST) begin
          sum_r <= sum_r + cur_byte;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/modbus_read_request_framer.sv =====
`timescale 1ns / 1ps
// Read-request framer for a serial data logger.
// The in_ stream carries one read request per transfer (start register and
// register count). For every request the out_ stream delivers a 36-byte
// logger frame, one byte per transfer, with tlast on the final end byte.
// The frame holds the sequence number, the logger serial, and a Modbus RTU
// function-03 request with its CRC-16, followed by an 8-bit checksum.
// The cfg_ port writes the logger serial (index 0) and the unit id (index 1);
// write it only while no frame is pending.
// With the serialiser idle, a request is first written into the queue and its
// first byte is then loaded into the output register. Throughput: one byte
// per cycle while out_tready is high, set by the byte serialiser; frames
// follow each other with no gap when the next request is already queued.
// A small request queue sits between the front end and the serialiser, so
// in_tready stays high until that queue is full, also while out_ is stalled.
// When out_tready is low the current byte holds and the serialiser waits.
// Reset empties the queue, clears the sequence number and the serial, and
// sets the unit id to 1.
module modbus_read_request_framer #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [15:0] start_register, [31:16] register_count
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] frame_byte
  output logic                          out_tlast,  // last_byte
  input  logic                          cfg_wr_en,
  input  logic [mrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import mrf_pkg::*;

  logic                             push;
  logic                             pop;
  mrf_req_t                         push_req;
  mrf_req_t                         head_req;
  mrf_qstat_t                       q_stat;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_req  (push_req)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head_req (head_req),
    .q_stat   (q_stat),
    .q_count  (q_count)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_req   (head_req),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The final byte of every frame is the end byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == END_BYTE)
    else $error("frame end byte mismatch");

  // The queue never holds more requests than it has slots
  assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("request queue overflow");

  // The serialiser only takes a request from a queue that holds one
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("request queue underflow");

endmodule
